// ===== hw/rtl/wstd_pkg.sv =====
// Shared constants for the work-stealing task dispatcher.
// Used by the top level and the partition divider; depends on nothing.
package wstd_pkg;

  localparam int unsigned WORKER_W   = 4;   // worker field of the input item
  localparam int unsigned NW_W       = 5;   // num_workers register
  localparam int unsigned TC_W       = 16;  // task_count register
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;   // worker, padded to a byte

  localparam logic [CFG_IDX_W-1:0] REG_NUM_WORKERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERIAL_MODE = 2'd2;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

endpackage

// ===== hw/rtl/wstd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wstd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/wstd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the range partition.
// Uses wstd_pkg for the divisor width.
module wstd_div #(
  parameter int unsigned DW = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DW-1:0]             dividend_i,
  input  logic [wstd_pkg::NW_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [DW-1:0]             quot_o,
  output logic [wstd_pkg::NW_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic                      run_q;
  logic                      done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [DW-1:0]             quot_q;
  logic [wstd_pkg::NW_W-1:0] rem_q;
  logic [wstd_pkg::NW_W-1:0] dvs_q;

  logic [wstd_pkg::NW_W:0]   trial;
  logic                      ge;
  logic [wstd_pkg::NW_W-1:0] rem_d;
  logic [DW-1:0]             quot_d;

  // bring down the next dividend bit and try the subtraction
  always_comb begin
    trial  = {rem_q, quot_q[DW-1]};
    ge     = trial >= {1'b0, dvs_q};
    rem_d  = ge ? wstd_pkg::NW_W'(trial - {1'b0, dvs_q}) : trial[wstd_pkg::NW_W-1:0];
    quot_d = {quot_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (run_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/work_stealing_task_dispatcher.sv =====
// Work-stealing task dispatcher: top level with handshake, control and state memories.
// Depends on wstd_pkg, wstd_ram and wstd_div.
//
// One transaction in gives one transaction out. A start (func 0) splits
// task_count tasks into contiguous ranges, one per active worker (a single
// range in serial mode), and answers with task_valid 0; the serial divider
// first works out tasks per range and the remainder, then every entry of the
// range memory is written, then the result goes to the output handshake. A
// request (func 1) reads the worker's steal pointer, then probes one range
// per cycle out of the range memory until a non-empty one is found (at most
// the number of active workers are probed). One item is in work at a time;
// the next is taken while a finished result still waits at the output
// register. After reset all ranges read as empty and each steal pointer as
// its own worker index.
module work_stealing_task_dispatcher #(
  parameter int unsigned MAX_WORKERS = 16,
  parameter int unsigned TASK_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [wstd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wstd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [wstd_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [3:0] worker, rest zero
  input  logic                                s_axis_tuser,   // [0] func
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [3:0] worker_echo, [TASK_WIDTH+3:4] task_index, rest zero
  output logic [((TASK_WIDTH + 4 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                                m_axis_tuser    // [0] task_valid
);

  localparam int unsigned TW    = TASK_WIDTH;
  localparam int unsigned IW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned CW    = $clog2(MAX_WORKERS + 1);
  localparam int unsigned OUT_B = ((TW + 4 + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWEEP,
    ST_SP_WAIT,
    ST_CHK,
    ST_RESP
  } state_e;

  state_e st_q;

  // configuration registers
  logic [wstd_pkg::NW_W-1:0] nw_q;
  logic [wstd_pkg::TC_W-1:0] tc_q;
  logic                      ser_q;

  // per-entry valid bits: an entry never written reads as its reset value
  logic [MAX_WORKERS-1:0] rng_vld_q;
  logic [MAX_WORKERS-1:0] sp_vld_q;

  // item in work
  logic [wstd_pkg::WORKER_W-1:0] wecho_q;
  logic [IW-1:0]                 wk_q;
  logic [IW-1:0]                 p_q;
  logic [CW-1:0]                 cnt_q;
  logic                          res_vld_q;
  logic [TW-1:0]                 res_idx_q;

  // partition
  logic [wstd_pkg::NW_W-1:0] part_w_q;
  logic [TW-1:0]             per_q;
  logic [wstd_pkg::NW_W-1:0] rem_q;
  logic [TW-1:0]             acc_q;
  logic [IW-1:0]             i_q;

  // output register
  logic                                m_vld_q;
  logic [wstd_pkg::WORKER_W-1:0]       m_worker_q;
  logic                                m_tv_q;
  logic [TW-1:0]                       m_idx_q;

  logic                          in_acc;
  logic                          in_func;
  logic [wstd_pkg::WORKER_W-1:0] in_worker;
  logic [CW-1:0]                 act;
  logic                          req_ok;

  logic                      div_start;
  logic                      div_done;
  logic [TW-1:0]             div_quot;
  logic [wstd_pkg::NW_W-1:0] div_rem;

  logic                 rng_we;
  logic [IW-1:0]        rng_waddr;
  logic [2*TW-1:0]      rng_wdata;
  logic [IW-1:0]        rng_raddr;
  logic [2*TW-1:0]      rng_rdata;
  logic                 sp_we;
  logic [IW-1:0]        sp_raddr;
  logic [IW-1:0]        sp_rdata;

  logic [IW-1:0]  sp_cur;
  logic [IW-1:0]  p_first;
  logic [IW-1:0]  p_nxt;
  logic [TW-1:0]  r_next;
  logic [TW-1:0]  r_end;
  logic           hit;
  logic           last_probe;
  logic           sw_in;
  logic [TW-1:0]  sw_len;
  logic [TW-1:0]  sw_acc_d;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_func   = s_axis_tuser;
  assign in_worker = s_axis_tdata[wstd_pkg::WORKER_W-1:0];

  // active worker count, clamped to 1..MAX_WORKERS
  always_comb begin
    if (nw_q == '0) begin
      act = CW'(1);
    end else if (32'(nw_q) > MAX_WORKERS) begin
      act = CW'(MAX_WORKERS);
    end else begin
      act = CW'(nw_q);
    end
  end

  assign req_ok = (32'(in_worker) < 32'(act)) && (32'(in_worker) < MAX_WORKERS) &&
                  !(ser_q && (in_worker != '0));

  // steal pointer of the requester, and where the scan begins
  always_comb begin
    sp_cur  = sp_vld_q[wk_q] ? sp_rdata : wk_q;
    p_first = (32'(sp_cur) >= 32'(act)) ? '0 : sp_cur;
    p_nxt   = (32'(p_q) + 32'd1 >= 32'(act)) ? '0 : IW'(32'(p_q) + 32'd1);
  end

  always_comb begin
    r_next     = rng_vld_q[p_q] ? rng_rdata[TW-1:0] : '0;
    r_end      = rng_vld_q[p_q] ? rng_rdata[2*TW-1:TW] : '0;
    hit        = (st_q == ST_CHK) && (r_next < r_end);
    last_probe = (32'(cnt_q) + 32'd1) >= 32'(act);
  end

  // partition sweep: first ranges take one extra task each
  always_comb begin
    sw_in    = 32'(i_q) < 32'(part_w_q);
    sw_len   = per_q + TW'(32'(i_q) < 32'(rem_q));
    sw_acc_d = acc_q + sw_len;
  end

  always_comb begin
    rng_we    = (st_q == ST_SWEEP) || hit;
    rng_waddr = (st_q == ST_SWEEP) ? i_q : p_q;
    if (st_q == ST_SWEEP) begin
      rng_wdata = sw_in ? {sw_acc_d, acc_q} : '0;
    end else begin
      rng_wdata = {r_end, r_next + TW'(1)};
    end
    // probe the next range while the current one is checked
    rng_raddr = (st_q == ST_SP_WAIT) ? p_first : p_nxt;
    sp_we     = hit;
    sp_raddr  = IW'(in_worker);
  end

  assign div_start = in_acc && (in_func == wstd_pkg::FUNC_START);

  wstd_div #(
    .DW (TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (TW'(tc_q)),
    .divisor_i  (ser_q ? wstd_pkg::NW_W'(1) : wstd_pkg::NW_W'(act)),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  wstd_ram #(
    .WIDTH (2 * TW),
    .DEPTH (MAX_WORKERS)
  ) u_rng_ram (
    .clk_i   (clk_i),
    .we_i    (rng_we),
    .waddr_i (rng_waddr),
    .wdata_i (rng_wdata),
    .raddr_i (rng_raddr),
    .rdata_o (rng_rdata)
  );

  wstd_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_WORKERS)
  ) u_sp_ram (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (wk_q),
    .wdata_i (p_q),
    .raddr_i (sp_raddr),
    .rdata_o (sp_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      nw_q      <= wstd_pkg::NW_W'(1);
      tc_q      <= '0;
      ser_q     <= 1'b0;
      rng_vld_q <= '0;
      sp_vld_q  <= '0;
      m_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wstd_pkg::REG_NUM_WORKERS: nw_q  <= cfg_wdata_i[wstd_pkg::NW_W-1:0];
          wstd_pkg::REG_TASK_COUNT:  tc_q  <= cfg_wdata_i[wstd_pkg::TC_W-1:0];
          wstd_pkg::REG_SERIAL_MODE: ser_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      // load a finished result, or drop the one just taken
      if ((st_q == ST_RESP) && (!m_vld_q || m_axis_tready)) begin
        m_vld_q <= 1'b1;
      end else if (m_vld_q && m_axis_tready) begin
        m_vld_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_func == wstd_pkg::FUNC_START) begin
              sp_vld_q <= '0;
              st_q     <= ST_DIV;
            end else if (req_ok) begin
              st_q <= ST_SP_WAIT;
            end else begin
              st_q <= ST_RESP;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            st_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          rng_vld_q[i_q] <= 1'b1;
          if (i_q == IW'(MAX_WORKERS - 1)) begin
            st_q <= ST_RESP;
          end
        end
        ST_SP_WAIT: begin
          st_q <= ST_CHK;
        end
        ST_CHK: begin
          if (hit) begin
            sp_vld_q[wk_q] <= 1'b1;
            st_q           <= ST_RESP;
          end else if (last_probe) begin
            st_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!m_vld_q || m_axis_tready) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        wecho_q   <= in_worker;
        wk_q      <= IW'(in_worker);
        res_vld_q <= 1'b0;
        res_idx_q <= '0;
        part_w_q  <= ser_q ? wstd_pkg::NW_W'(1) : wstd_pkg::NW_W'(act);
      end
      ST_DIV: begin
        per_q <= div_quot;
        rem_q <= div_rem;
        acc_q <= '0;
        i_q   <= '0;
      end
      ST_SWEEP: begin
        if (sw_in) begin
          acc_q <= sw_acc_d;
        end
        i_q <= IW'(32'(i_q) + 32'd1);
      end
      ST_SP_WAIT: begin
        p_q   <= p_first;
        cnt_q <= '0;
      end
      ST_CHK: begin
        if (hit) begin
          res_vld_q <= 1'b1;
          res_idx_q <= r_next;
        end else begin
          p_q   <= p_nxt;
          cnt_q <= CW'(32'(cnt_q) + 32'd1);
        end
      end
      ST_RESP: begin
        if (!m_vld_q || m_axis_tready) begin
          m_worker_q <= wecho_q;
          m_tv_q     <= res_vld_q;
          m_idx_q    <= res_idx_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = OUT_B'({m_idx_q, m_worker_q});
  assign m_axis_tuser  = m_tv_q;

endmodule

// ===== bench/wstd_dispatch_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the work-stealing task dispatcher: tracks register writes, predicts the
// grant for every accepted request and compares it with the result stream.
// Depends on wstd_pkg.
module wstd_dispatch_checker #(
  parameter int unsigned MAX_WORKERS = 16,
  parameter int unsigned TASK_WIDTH  = 16,
  parameter int unsigned OUT_DATA_W  = ((TASK_WIDTH + 4 + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wstd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wstd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            req_valid_i,
  input  logic                            req_ready_i,
  input  logic [wstd_pkg::IN_DATA_W-1:0]  req_data_i,   // [3:0] worker
  input  logic                            req_user_i,   // [0] func
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  logic [OUT_DATA_W-1:0]           res_data_i,   // [3:0] worker_echo, then task_index
  input  logic                            res_user_i,   // [0] task_valid
  output int unsigned                     outstanding_o,
  output int unsigned                     errors_o
);

  typedef struct packed {
    logic [wstd_pkg::WORKER_W-1:0] worker;
    logic                          granted;
    logic [TASK_WIDTH-1:0]         index;
  } grant_t;

  logic [wstd_pkg::NW_W-1:0] num_workers_q;
  logic [wstd_pkg::TC_W-1:0] task_count_q;
  logic                      serial_q;
  logic [TASK_WIDTH-1:0]     range_next [MAX_WORKERS];
  logic [TASK_WIDTH-1:0]     range_stop [MAX_WORKERS];
  int unsigned               steal_ptr  [MAX_WORKERS];
  grant_t                    grant_q [$];
  int unsigned               fail_count;

  // zero acts as one, anything above the table size is clamped
  function automatic int unsigned active_workers();
    if (num_workers_q == '0) return 1;
    if (num_workers_q > MAX_WORKERS) return MAX_WORKERS;
    return 32'(num_workers_q);
  endfunction

  function automatic void split_tasks();
    int unsigned w;
    int unsigned per;
    int unsigned extra;
    int unsigned acc;
    w     = serial_q ? 1 : active_workers();
    per   = 32'(task_count_q) / w;
    extra = 32'(task_count_q) % w;
    acc   = 0;
    for (int unsigned i = 0; i < MAX_WORKERS; i++) begin
      if (i < w) begin
        range_next[i] = TASK_WIDTH'(acc);
        acc += per + ((i < extra) ? 1 : 0);
        range_stop[i] = TASK_WIDTH'(acc);
      end else begin
        range_next[i] = '0;
        range_stop[i] = '0;
      end
      steal_ptr[i] = i;
    end
  endfunction

  // scan round-robin from the worker's sticky pointer; the pointer only moves on a hit
  function automatic grant_t steal_task(int unsigned w);
    int unsigned count;
    int unsigned p;
    grant_t      g;
    g     = '0;
    count = active_workers();
    p     = steal_ptr[w];
    if (p >= count) p = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (range_next[p] < range_stop[p]) begin
        g.granted     = 1'b1;
        g.index       = range_next[p];
        range_next[p] = range_next[p] + 1'b1;
        steal_ptr[w]  = p;
        return g;
      end
      p = (p + 1 >= count) ? 0 : p + 1;
    end
    return g;
  endfunction

  function automatic grant_t dispatch_item(logic func, logic [wstd_pkg::WORKER_W-1:0] worker);
    grant_t g;
    g = '0;
    if (func == wstd_pkg::FUNC_START) begin
      split_tasks();
    end else if (32'(worker) < active_workers() && !(serial_q && worker != 0)) begin
      g = steal_task(32'(worker));
    end
    g.worker = worker;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    grant_t got;
    if (!rst_ni) begin
      num_workers_q = wstd_pkg::NW_W'(1);
      task_count_q  = '0;
      serial_q      = 1'b0;
      for (int unsigned i = 0; i < MAX_WORKERS; i++) begin
        range_next[i] = '0;
        range_stop[i] = '0;
        steal_ptr[i]  = i;
      end
      grant_q.delete();
      fail_count = 0;
      outstanding_o <= 0;
      errors_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wstd_pkg::REG_NUM_WORKERS: num_workers_q = cfg_wdata_i[wstd_pkg::NW_W-1:0];
          wstd_pkg::REG_TASK_COUNT:  task_count_q  = cfg_wdata_i[wstd_pkg::TC_W-1:0];
          wstd_pkg::REG_SERIAL_MODE: serial_q      = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        grant_q.push_back(dispatch_item(req_user_i, req_data_i[wstd_pkg::WORKER_W-1:0]));
      end
      if (res_valid_i && res_ready_i) begin
        got.worker  = res_data_i[wstd_pkg::WORKER_W-1:0];
        got.granted = res_user_i;
        got.index   = res_data_i[wstd_pkg::WORKER_W+TASK_WIDTH-1:wstd_pkg::WORKER_W];
        if (grant_q.size() == 0) begin
          $error("unexpected result transaction for worker %0d", got.worker);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (got.worker !== want.worker) begin
            $error("worker_echo: expected %0d, got %0d", want.worker, got.worker);
            fail_count++;
          end
          if (got.granted !== want.granted) begin
            $error("task_valid: expected %0d, got %0d", want.granted, got.granted);
            fail_count++;
          end
          if (got.index !== want.index) begin
            $error("task_index: expected %0d, got %0d", want.index, got.index);
            fail_count++;
          end
        end
      end
      outstanding_o <= grant_q.size();
      errors_o      <= fail_count;
    end
  end

endmodule

// ===== bench/tb_work_stealing_task_dispatcher.sv =====
`timescale 1ns / 1ps
// Testbench top for the work-stealing task dispatcher: clock, reset, stimulus and verdict.
// Depends on wstd_pkg, the dispatcher RTL and wstd_dispatch_checker.
module tb_work_stealing_task_dispatcher;

  localparam int unsigned MAX_WORKERS  = 16;
  localparam int unsigned TASK_WIDTH   = 16;
  localparam int unsigned OUT_DATA_W   = ((TASK_WIDTH + 4 + 7) / 8) * 8;
  localparam int unsigned ITEM_TARGET  = 1550;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [wstd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wstd_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [wstd_pkg::IN_DATA_W-1:0]  s_axis_tdata;    // [3:0] worker
  logic                            s_axis_tuser;    // [0] func
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [OUT_DATA_W-1:0]           m_axis_tdata;    // [3:0] worker_echo, [19:4] task_index
  logic                            m_axis_tuser;    // [0] task_valid

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned items_sent;
  bit          no_gaps;
  bit          hold_sink;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  work_stealing_task_dispatcher #(
    .MAX_WORKERS(MAX_WORKERS),
    .TASK_WIDTH (TASK_WIDTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  wstd_dispatch_checker #(
    .MAX_WORKERS(MAX_WORKERS),
    .TASK_WIDTH (TASK_WIDTH),
    .OUT_DATA_W (OUT_DATA_W)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_user_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_user_i   (m_axis_tuser),
    .outstanding_o(outstanding),
    .errors_o     (fail_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned clamp_workers(int unsigned nw);
    if (nw == 0) return 1;
    if (nw > MAX_WORKERS) return MAX_WORKERS;
    return nw;
  endfunction

  task automatic send_item(logic func, logic [wstd_pkg::WORKER_W-1:0] worker);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(wstd_pkg::IN_DATA_W - wstd_pkg::WORKER_W){1'b0}}, worker};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic write_config(int unsigned nw, int unsigned tc, bit serial);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= wstd_pkg::REG_NUM_WORKERS;
    cfg_wdata_i <= wstd_pkg::CFG_DATA_W'(nw);
    @(posedge clk_i);
    cfg_idx_i   <= wstd_pkg::REG_TASK_COUNT;
    cfg_wdata_i <= wstd_pkg::CFG_DATA_W'(tc);
    @(posedge clk_i);
    cfg_idx_i   <= wstd_pkg::REG_SERIAL_MODE;
    cfg_wdata_i <= wstd_pkg::CFG_DATA_W'(serial);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // drop valid and hold until every grant has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // result side: ready stretches broken by gaps, plus one long hold-off on request
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_sink = 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
        gap = pick_gap();
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned nw;
    int unsigned tc;
    int unsigned eff_w;
    int unsigned n;
    int unsigned r;
    bit          serial;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    items_sent    = 0;
    no_gaps       = 1'b0;
    hold_sink     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: empty ranges, requester beyond the worker count, empty job
    send_item(wstd_pkg::FUNC_REQUEST, 4'd0);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd15);
    send_item(wstd_pkg::FUNC_START, 4'd0);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd0);
    wait_idle();
    // zero workers acts as one; drain the range and saturate
    write_config(0, 3, 1'b0);
    send_item(wstd_pkg::FUNC_START, 4'd0);
    repeat (4) send_item(wstd_pkg::FUNC_REQUEST, 4'd0);
    wait_idle();
    // widest split of the largest job
    write_config(16, 65535, 1'b0);
    send_item(wstd_pkg::FUNC_START, 4'd0);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd15);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd0);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd8);
    wait_idle();
    // over-range worker count clamps; an empty range steals with wrap-around
    write_config(31, 5, 1'b0);
    send_item(wstd_pkg::FUNC_START, 4'd0);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd3);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd7);
    wait_idle();
    // serial mode serves worker 0 only
    write_config(4, 4, 1'b1);
    send_item(wstd_pkg::FUNC_START, 4'd0);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd1);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd0);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd0);
    wait_idle();
    // move worker 1's pointer away, then shrink so the pointer goes stale
    write_config(8, 8, 1'b0);
    send_item(wstd_pkg::FUNC_START, 4'd0);
    repeat (3) send_item(wstd_pkg::FUNC_REQUEST, 4'd1);
    wait_idle();
    write_config(2, 8, 1'b0);
    send_item(wstd_pkg::FUNC_REQUEST, 4'd1);
    wait_idle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 19);
      if (r == 0) nw = 0;
      else if (r == 1) nw = $urandom_range(17, 31);
      else if (r == 2) nw = 16;
      else if (r == 3) nw = 1;
      else nw = $urandom_range(1, 16);
      r = $urandom_range(0, 19);
      if (r == 0) tc = 0;
      else if (r == 1) tc = 65535;
      else if (r == 2) tc = $urandom_range(0, 65535);
      else tc = $urandom_range(1, 80);
      serial = ($urandom_range(0, 3) == 0);
      eff_w  = clamp_workers(nw);
      write_config(nw, tc, serial);
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 60);
      if (phase == 3) begin
        // keep offering while the result side holds off, so the input stalls
        hold_sink = 1'b1;
        no_gaps   = 1'b1;
        n         = 40;
      end
      if ($urandom_range(0, 6) != 0) begin
        send_item(wstd_pkg::FUNC_START, 4'($urandom_range(0, 15)));
      end
      repeat (n) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_item(wstd_pkg::FUNC_START, 4'($urandom_range(0, 15)));
        else if (r < 3) send_item(wstd_pkg::FUNC_REQUEST, 4'($urandom_range(0, 15)));
        else if (serial) send_item(wstd_pkg::FUNC_REQUEST, 4'd0);
        else send_item(wstd_pkg::FUNC_REQUEST, 4'($urandom_range(0, eff_w - 1)));
      end
      wait_idle();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
